// ===== hdl/text_terminal_cursor_engine_core_assert.svh =====
// Assertion macros for the terminal RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef TEXT_TERMINAL_CURSOR_ENGINE_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CURSOR_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// The condition holds at every clock edge outside reset.
`define TT_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define TT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define TT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define TT_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define TT_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define TT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== hdl/tterm_pkg.sv =====
package tterm_pkg;

    // Default screen geometry.
    localparam int COLUMNS_DEF = 100;
    localparam int ROWS_DEF    = 37;

    // Fixed field widths of the request and result.
    localparam int COL_W  = 7;
    localparam int ROW_W  = 6;
    localparam int CHAR_W = 8;
    localparam int CLR_W  = 3;
    localparam int CELL_W = CHAR_W + 2 * CLR_W;

    // Request modes.
    localparam logic [1:0] MODE_CHAR  = 2'd0;
    localparam logic [1:0] MODE_PLACE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Pending prefix codes.
    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_PCT  = 2'd1;
    localparam logic [1:0] PFX_DOL  = 2'd2;
    localparam logic [1:0] PFX_HSH  = 2'd3;

    // Special character codes.
    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_DOL = 8'h24;
    localparam logic [7:0] CH_HSH = 8'h23;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_BS  = 8'h08;

    // Colors after reset.
    localparam logic [CLR_W-1:0] FG_RESET = 3'd7;
    localparam logic [CLR_W-1:0] BG_RESET = 3'd0;

    // Maps a color letter to {valid, index}.
    function automatic logic [CLR_W:0] colour_code(input logic [CHAR_W-1:0] ch);
        logic [CLR_W:0] res;
        case (ch)
            "k":     res = {1'b1, 3'd0};
            "b":     res = {1'b1, 3'd1};
            "g":     res = {1'b1, 3'd2};
            "c":     res = {1'b1, 3'd3};
            "r":     res = {1'b1, 3'd4};
            "m":     res = {1'b1, 3'd5};
            "y":     res = {1'b1, 3'd6};
            "w":     res = {1'b1, 3'd7};
            default: res = '0;
        endcase
        return res;
    endfunction

endpackage

// ===== hdl/text_terminal_cursor_engine_core.sv =====
// Text terminal with a COLUMNS x ROWS screen of character cells held in one
// synchronous memory with a single write port and a single registered read
// port. Printable and control characters, color prefixes and cursor placement
// are done straight from idle when the result register is free. A cell read
// goes through request, memory read and result, in that order. A character that
// runs past the bottom row scrolls the screen: the rows are addressed through
// a circular top row offset, so a scroll only clears one line. A clear-screen
// request sweeps every cell through the write port. After reset the same
// sweep runs once before the first request is taken. One request is in work
// at a time; a finished result may wait in the output register while the next
// request is taken.
`include "text_terminal_cursor_engine_core_assert.svh"

module text_terminal_cursor_engine_core #(
    parameter int COLUMNS = tterm_pkg::COLUMNS_DEF,
    parameter int ROWS    = tterm_pkg::ROWS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], column[14:8], row[20:15], zero fill
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_char[7:0], cell_fg[10:8], cell_bg[13:11], cursor_col_now[20:14],
    // cursor_row_now[26:21], fg_now[29:27], bg_now[32:30], zero fill
    output logic [39:0] m_tdata
);
    import tterm_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_READ  = 4'b0100,
        ST_PUT   = 4'b1000
    } state_t;

    // Maps a screen row and column to a memory address through the top offset.
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col,
                                                    input logic [ROW_W-1:0] top);
        logic [ROW_W:0] phys;
        phys = {1'b0, row} + {1'b0, top};
        if (phys >= (ROW_W + 1)'(ROWS)) begin
            phys = phys - (ROW_W + 1)'(ROWS);
        end
        return ADDR_W'(phys[ROW_W-1:0]) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // Request fields.
    logic [1:0]        in_mode;
    logic [CHAR_W-1:0] in_byte;
    logic [COL_W-1:0]  in_col;
    logic [ROW_W-1:0]  in_row;

    assign in_mode = s_tuser;
    assign in_byte = s_tdata[7:0];
    assign in_col  = s_tdata[14:8];
    assign in_row  = s_tdata[20:15];

    // Control and terminal state.
    state_t            state_reg;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [CLR_W-1:0]  fg_reg, fg_next;
    logic [CLR_W-1:0]  bg_reg, bg_next;
    logic [1:0]        pfx_reg, pfx_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_end_reg;
    logic              sweep_reply_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0] res_cell_reg;
    logic              m_valid_reg;
    logic [39:0]       m_data_reg;

    // Screen memory.
    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;

    // Decode results.
    logic              s_accept;
    logic              out_free;
    logic              out_load;
    logic [39:0]       out_data;
    logic              do_put;
    logic              do_nl;
    logic              do_scroll;
    logic              do_clear;
    logic              rd_issue;
    logic              immediate;
    logic [COL_W:0]    tab_col;
    logic [CLR_W:0]    colour;
    logic [ADDR_W-1:0] cursor_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [ADDR_W-1:0] scroll_base;

    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign cursor_addr = cell_addr(cursor_row_reg, cursor_col_reg, top_reg);
    assign read_addr   = cell_addr(in_row, in_col, top_reg);
    assign scroll_base = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);
    assign tab_col     = ({1'b0, cursor_col_reg} + (COL_W + 1)'(4)) & ~(COL_W + 1)'(3);
    assign colour      = colour_code(in_byte);

    // Next terminal state for the request at the input.
    always_comb begin
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;
        fg_next         = fg_reg;
        bg_next         = bg_reg;
        pfx_next        = pfx_reg;
        top_next        = top_reg;
        do_put          = 1'b0;
        do_nl           = 1'b0;
        do_scroll       = 1'b0;
        do_clear        = 1'b0;
        rd_issue        = 1'b0;
        rd_ok_next      = 1'b0;
        case (in_mode)
            MODE_CHAR: begin
                if (pfx_reg != PFX_NONE) begin
                    // A pending prefix is consumed by this byte.
                    pfx_next = PFX_NONE;
                    if (pfx_reg == PFX_PCT) begin
                        if (in_byte == CH_PCT) begin
                            do_put = 1'b1;
                        end
                    end else if ((pfx_reg == PFX_DOL && in_byte == CH_DOL) ||
                                 (pfx_reg == PFX_HSH && in_byte == CH_HSH)) begin
                        do_put = 1'b1;
                    end else if (colour[CLR_W]) begin
                        if (pfx_reg == PFX_DOL) begin
                            fg_next = colour[CLR_W-1:0];
                        end else begin
                            bg_next = colour[CLR_W-1:0];
                        end
                    end
                end else begin
                    case (in_byte)
                        CH_PCT: pfx_next = PFX_PCT;
                        CH_DOL: pfx_next = PFX_DOL;
                        CH_HSH: pfx_next = PFX_HSH;
                        CH_LF:  do_nl = 1'b1;
                        CH_CR:  cursor_col_next = '0;
                        CH_TAB: begin
                            if (tab_col >= (COL_W + 1)'(COLUMNS - 1)) begin
                                do_nl = 1'b1;
                            end else begin
                                cursor_col_next = tab_col[COL_W-1:0];
                            end
                        end
                        CH_BS: begin
                            if (cursor_col_reg != '0) begin
                                cursor_col_next = cursor_col_reg - COL_W'(1);
                            end else begin
                                if (cursor_row_reg != '0) begin
                                    cursor_row_next = cursor_row_reg - ROW_W'(1);
                                end
                                cursor_col_next = COL_W'(COLUMNS - 1);
                            end
                        end
                        default: do_put = 1'b1;
                    endcase
                end
                // A printed character advances the cursor and may wrap.
                if (do_put) begin
                    if ({1'b0, cursor_col_reg} + (COL_W + 1)'(1) >= (COL_W + 1)'(COLUMNS)) begin
                        do_nl = 1'b1;
                    end else begin
                        cursor_col_next = cursor_col_reg + COL_W'(1);
                    end
                end
                // A new line past the bottom row scrolls.
                if (do_nl) begin
                    cursor_col_next = '0;
                    if ({1'b0, cursor_row_reg} + (ROW_W + 1)'(1) >= (ROW_W + 1)'(ROWS)) begin
                        do_scroll = 1'b1;
                    end else begin
                        cursor_row_next = cursor_row_reg + ROW_W'(1);
                    end
                end
            end
            MODE_PLACE: begin
                if ({1'b0, in_col} < (COL_W + 1)'(COLUMNS)) begin
                    cursor_col_next = in_col;
                end
                if ({1'b0, in_row} < (ROW_W + 1)'(ROWS)) begin
                    cursor_row_next = in_row;
                end
            end
            MODE_CLEAR: begin
                do_clear        = 1'b1;
                cursor_col_next = '0;
                cursor_row_next = '0;
                top_next        = '0;
            end
            default: begin
                rd_issue   = 1'b1;
                rd_ok_next = ({1'b0, in_col} < (COL_W + 1)'(COLUMNS)) &&
                             ({1'b0, in_row} < (ROW_W + 1)'(ROWS));
            end
        endcase
        // The old top row becomes the new bottom row.
        if (do_scroll) begin
            if ({1'b0, top_reg} + (ROW_W + 1)'(1) >= (ROW_W + 1)'(ROWS)) begin
                top_next = '0;
            end else begin
                top_next = top_reg + ROW_W'(1);
            end
        end
    end

    assign immediate = !(do_scroll || do_clear || rd_issue);

    // Result register load, either straight from a request or from a finished one.
    assign out_load = (state_reg == ST_IDLE && s_accept && immediate && out_free) ||
                      (state_reg == ST_PUT && out_free);

    always_comb begin
        if (state_reg == ST_IDLE) begin
            out_data = {7'd0, bg_next, fg_next, cursor_row_next, cursor_col_next,
                        CELL_W'(0)};
        end else begin
            out_data = {7'd0, bg_reg, fg_reg, cursor_row_reg, cursor_col_reg,
                        res_cell_reg};
        end
    end

    // Write port: a printed cell on a request, zeros during a sweep.
    always_comb begin
        if (state_reg == ST_SWEEP) begin
            mem_we    = 1'b1;
            mem_waddr = sweep_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = s_accept && do_put;
            mem_waddr = cursor_addr;
            mem_wdata = {bg_reg, fg_reg, in_byte};
        end
    end

    // Screen memory. Reads are only issued from idle, after all earlier writes.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (s_accept && rd_issue && rd_ok_next) begin
            rd_data_reg <= screen_mem[read_addr];
        end
    end

    // Sequencer and terminal state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_SWEEP;
            sweep_addr_reg  <= '0;
            sweep_end_reg   <= ADDR_W'(CELLS - 1);
            sweep_reply_reg <= 1'b0;
            cursor_col_reg  <= '0;
            cursor_row_reg  <= '0;
            fg_reg          <= FG_RESET;
            bg_reg          <= BG_RESET;
            pfx_reg         <= PFX_NONE;
            top_reg         <= '0;
            rd_ok_reg       <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cursor_col_reg <= cursor_col_next;
                        cursor_row_reg <= cursor_row_next;
                        fg_reg         <= fg_next;
                        bg_reg         <= bg_next;
                        pfx_reg        <= pfx_next;
                        top_reg        <= top_next;
                        rd_ok_reg      <= rd_ok_next;
                        if (do_clear) begin
                            state_reg       <= ST_SWEEP;
                            sweep_addr_reg  <= '0;
                            sweep_end_reg   <= ADDR_W'(CELLS - 1);
                            sweep_reply_reg <= 1'b1;
                        end else if (do_scroll) begin
                            state_reg       <= ST_SWEEP;
                            sweep_addr_reg  <= scroll_base;
                            sweep_end_reg   <= scroll_base + ADDR_W'(COLUMNS - 1);
                            sweep_reply_reg <= 1'b1;
                        end else if (rd_issue) begin
                            state_reg <= ST_READ;
                        end else if (!out_free) begin
                            state_reg <= ST_PUT;
                        end
                    end
                end
                ST_SWEEP: begin
                    if (sweep_addr_reg == sweep_end_reg) begin
                        state_reg <= sweep_reply_reg ? ST_PUT : ST_IDLE;
                    end else begin
                        sweep_addr_reg <= sweep_addr_reg + ADDR_W'(1);
                    end
                end
                ST_READ: begin
                    state_reg <= ST_PUT;
                end
                ST_PUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Cell field of a pending result.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_accept) begin
            res_cell_reg <= '0;
        end else if (state_reg == ST_READ) begin
            res_cell_reg <= rd_ok_reg ? rd_data_reg : '0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= out_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `TT_ASSERT_ALWAYS(a_cursor_range, aclk, aresetn, (cursor_col_reg < COLUMNS) && (cursor_row_reg < ROWS))
    `TT_ASSERT_ALWAYS(a_top_range, aclk, aresetn, top_reg < ROWS)
    `TT_ASSERT_IMPLY(a_load_free, aclk, aresetn, out_load, !m_valid_reg || m_tready)
    `TT_ASSERT_IMPLY(a_sweep_bound, aclk, aresetn, state_reg == ST_SWEEP, (sweep_addr_reg <= sweep_end_reg) && (sweep_end_reg < CELLS))
    `TT_ASSERT_NEXT(a_read_follows, aclk, aresetn, s_accept && rd_issue, state_reg == ST_READ)

endmodule
